// ===== design/lru_working_set_page_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// LRU working set page table - assertion macros
// Shared concurrent assertion forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef LRU_WORKING_SET_PAGE_TABLE_TOP_MACROS_SVH
`define LRU_WORKING_SET_PAGE_TABLE_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LWSPT_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("lwspt: invariant violated");

// An antecedent that must be followed by the consequent in the next cycle.
`define LWSPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lwspt: sequencing violated");

// An antecedent that must be accompanied by the consequent in the same cycle.
`define LWSPT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lwspt: implication violated");

`endif

// ===== design/lwspt_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU working set page table - package
// Widths, limits, codes and the types shared between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lwspt_pkg;

    // Page and frame numbers span their whole field, so every code is in range.
    localparam int PAGE_W      = 6;
    localparam int FRAME_W     = 6;
    localparam int PAGE_COUNT  = 2 ** PAGE_W;
    localparam int FRAME_COUNT = 2 ** FRAME_W;
    localparam int SET_LIMIT   = 4;
    localparam int CNT_W       = $clog2(SET_LIMIT + 1);

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_EVICT = 2'd2,
        REQ_NONE  = 2'd3
    } req_e_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_REJECT = 2'd2,
        ST_EMPTY  = 2'd3
    } status_e_t;

    typedef enum logic [1:0] {
        ORD_HOLD    = 2'd0,
        ORD_PROMOTE = 2'd1,
        ORD_APPEND  = 2'd2,
        ORD_EVICT   = 2'd3
    } ord_op_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        ord_op_t            op;
        logic [PAGE_W-1:0]  page;
    } ord_cmd_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  head;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   count_next;
    } ord_stat_t;

endpackage

`default_nettype wire

// ===== design/lwspt_ram.sv =====
// ----------------------------------------------------------------------------
// LRU working set page table - generic RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lwspt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lwspt_order.sv =====
// ----------------------------------------------------------------------------
// LRU working set page table - recency order
// Holds the resident pages from least to most recent and the resident count.
// ----------------------------------------------------------------------------
`default_nettype none

module lwspt_order
    import lwspt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ord_cmd_t  cmd,
    output ord_stat_t      stat
);

    logic [PAGE_W-1:0]    order_reg  [SET_LIMIT];
    logic [PAGE_W-1:0]    order_next [SET_LIMIT];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [SET_LIMIT-1:0] match;
    logic [SET_LIMIT-1:0] from_match;

    // Positions holding the requested page, and every position at or after it.
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < SET_LIMIT; i++)
        begin
            match[i]      = (order_reg[i] == cmd.page) && (CNT_W'(i) < count_reg);
            seen          = seen | match[i];
            from_match[i] = seen;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < SET_LIMIT; i++)
        begin
            order_next[i] = order_reg[i];
        end
        case (cmd.op)
            ORD_PROMOTE:
            begin
                for (int i = 0; i < SET_LIMIT; i++)
                begin
                    if (from_match[i] && (i + 1 < SET_LIMIT) && (CNT_W'(i + 1) < count_reg))
                    begin
                        order_next[i] = order_reg[(i + 1) % SET_LIMIT];
                    end
                    if (from_match[SET_LIMIT-1] && (CNT_W'(i) == count_reg - CNT_W'(1)))
                    begin
                        order_next[i] = cmd.page;
                    end
                end
            end
            ORD_APPEND:
            begin
                for (int i = 0; i < SET_LIMIT; i++)
                begin
                    if (CNT_W'(i) == count_reg)
                    begin
                        order_next[i] = cmd.page;
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end
            ORD_EVICT:
            begin
                for (int i = 0; i < SET_LIMIT; i++)
                begin
                    if ((i + 1 < SET_LIMIT) && (CNT_W'(i + 1) < count_reg))
                    begin
                        order_next[i] = order_reg[(i + 1) % SET_LIMIT];
                    end
                end
                count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SET_LIMIT; i++)
        begin
            order_reg[i] <= order_next[i];
        end
    end

    assign stat.head       = order_reg[0];
    assign stat.count      = count_reg;
    assign stat.count_next = count_next;

endmodule

`default_nettype wire

// ===== design/lru_working_set_page_table_top.sv =====
// ----------------------------------------------------------------------------
// LRU working set page table - top level
// A request transaction (req_type, page, frame) enters on the in_ channel and
// yields exactly one result transaction (status, frame_out, evicted_page,
// set_empty, set_full) on the out_ channel. Both channels use valid and stall.
// An accepted transaction moves to the execute state, and its result is
// registered in the output register that drives out_valid. The frame RAM
// read is registered and followed by its read-modify-write in the execute
// state; one request is in progress at a time, and in_stall is high in every
// execute cycle. A finished result waits in the output register while a
// new request is still accepted; only if that result is still stalled when
// the next one is ready does the block stay in execute, keeping in_stall high.
// Reset (rst_n low, asynchronous) empties the working set: the per-page valid
// flags and the resident count are cleared at once, with no clearing pass,
// and the block accepts a request as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_working_set_page_table_top_macros.svh"

module lru_working_set_page_table_top
    import lwspt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [PAGE_W-1:0]  page,
    input  wire logic [FRAME_W-1:0] frame,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [FRAME_W-1:0]      frame_out,
    output logic [PAGE_W-1:0]       evicted_page,
    output logic                    set_empty,
    output logic                    set_full
);

    state_t               state_reg;
    state_t               state_next;

    // The request held while it is worked on.
    req_e_t               req_type_reg;
    logic [PAGE_W-1:0]    req_page_reg;
    logic [FRAME_W-1:0]   req_frame_reg;

    // One valid flag per page; the frames themselves live in the RAM.
    logic [PAGE_COUNT-1:0] pt_valid_reg;

    logic                 out_valid_reg;
    status_e_t            status_reg;
    logic [FRAME_W-1:0]   frame_out_reg;
    logic [PAGE_W-1:0]    evicted_page_reg;
    logic                 set_empty_reg;
    logic                 set_full_reg;

    logic                 accept;
    logic                 commit;
    logic                 ram_we;
    logic [PAGE_W-1:0]    ram_raddr;
    logic [FRAME_W-1:0]   ram_rdata;
    logic                 valid_set;
    logic                 valid_clr;
    status_e_t            res_status;
    logic [FRAME_W-1:0]   res_frame;
    logic [PAGE_W-1:0]    res_evict;
    ord_cmd_t             ord_cmd;
    ord_stat_t            ord_stat;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // An evict needs the frame of the least recent page, every other request
    // the frame of the page it names.
    assign ram_raddr = (req_e_t'(req_type) == REQ_EVICT) ? ord_stat.head : page;

    lwspt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGE_COUNT)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_page_reg),
        .wdata (req_frame_reg),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lwspt_order u_order (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ord_cmd),
        .stat  (ord_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The execute cycle decides the result, updates the recency order and
    // writes the RAM, but only once the output register is free to take it.
    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        ord_cmd.op   = ORD_HOLD;
        ord_cmd.page = req_page_reg;
        ram_we     = 1'b0;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        res_status = ST_OK;
        res_frame  = '0;
        res_evict  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                    case (req_type_reg)
                        REQ_READ:
                        begin
                            if (pt_valid_reg[req_page_reg])
                            begin
                                ord_cmd.op = ORD_PROMOTE;
                                res_frame  = ram_rdata;
                            end
                            else
                            begin
                                res_status = ST_MISS;
                            end
                        end
                        REQ_ADD:
                        begin
                            if (pt_valid_reg[req_page_reg])
                            begin
                                ram_we     = 1'b1;
                                ord_cmd.op = ORD_PROMOTE;
                            end
                            else if (ord_stat.count >= CNT_W'(SET_LIMIT))
                            begin
                                res_status = ST_REJECT;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                valid_set  = 1'b1;
                                ord_cmd.op = ORD_APPEND;
                            end
                        end
                        REQ_EVICT:
                        begin
                            if (ord_stat.count == '0)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                valid_clr  = 1'b1;
                                ord_cmd.op = ORD_EVICT;
                                res_evict  = ord_stat.head;
                                res_frame  = ram_rdata;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (valid_set)
            begin
                pt_valid_reg[req_page_reg] <= 1'b1;
            end
            if (valid_clr)
            begin
                pt_valid_reg[ord_stat.head] <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg  <= req_e_t'(req_type);
            req_page_reg  <= page;
            req_frame_reg <= frame;
        end
        if (commit)
        begin
            status_reg       <= res_status;
            frame_out_reg    <= res_frame;
            evicted_page_reg <= res_evict;
            set_empty_reg    <= (ord_stat.count_next == '0);
            set_full_reg     <= (ord_stat.count_next >= CNT_W'(SET_LIMIT));
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame_out    = frame_out_reg;
    assign evicted_page = evicted_page_reg;
    assign set_empty    = set_empty_reg;
    assign set_full     = set_full_reg;

    `LWSPT_ASSERT_ALWAYS(a_valid_matches_count, clk, rst_n,
        $countones(pt_valid_reg) == int'(ord_stat.count))
    `LWSPT_ASSERT_NEXT(a_accept_starts_exec, clk, rst_n,
        in_valid && !in_stall, state_reg == S_EXEC)
    `LWSPT_ASSERT_NEXT(a_commit_shows_result, clk, rst_n,
        commit, out_valid_reg && state_reg == S_IDLE)
    `LWSPT_ASSERT_IMPLY(a_flags_exclusive, clk, rst_n,
        out_valid_reg, !(set_empty_reg && set_full_reg))

endmodule

`default_nettype wire
